### rtl/ntd_pkg.sv
package ntd_pkg;

    localparam int BEAT_W = 16;
    localparam int FREQ_W = 13;
    localparam int DUR_W = 20;
    localparam int DIV_W = 5;
    localparam int STEP_W = 4;

    localparam logic [BEAT_W-1:0] DEFAULT_BEAT = 16'd750;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_FLAT = 8'h62;
    localparam logic [7:0] CH_REST = 8'h30;
    localparam logic [7:0] CH_TOP = 8'h37;
    localparam logic signed [4:0] LOW_OCT_MIN_SEMI = 5'sd9;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic [3:0] pad;
        logic dotted;
        logic signed [5:0] length_code;
        logic signed [4:0] octave;
        logic [7:0] degree_char;
        logic [7:0] accidental_char;
    } note_t;

    typedef struct packed {
        logic [5:0] pad;
        logic [DUR_W-1:0] duration_ms;
        logic [FREQ_W-1:0] frequency_hz;
        logic valid_res;
    } result_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
        logic out_free;
    } sts_t;

    function automatic logic [FREQ_W-1:0] tone_of(input logic [3:0] semi);
        logic [FREQ_W-1:0] f;
        begin
            case (semi)
                4'd0: f = 13'd261;
                4'd1: f = 13'd277;
                4'd2: f = 13'd293;
                4'd3: f = 13'd311;
                4'd4: f = 13'd329;
                4'd5: f = 13'd349;
                4'd6: f = 13'd369;
                4'd7: f = 13'd392;
                4'd8: f = 13'd415;
                4'd9: f = 13'd440;
                4'd10: f = 13'd466;
                4'd11: f = 13'd493;
                default: f = 13'd0;
            endcase
            return f;
        end
    endfunction

    function automatic logic [3:0] semitone_of(input logic [2:0] deg);
        logic [3:0] s;
        begin
            case (deg)
                3'd2: s = 4'd2;
                3'd3: s = 4'd4;
                3'd4: s = 4'd5;
                3'd5: s = 4'd7;
                3'd6: s = 4'd9;
                3'd7: s = 4'd11;
                default: s = 4'd0;
            endcase
            return s;
        end
    endfunction

endpackage

### rtl/note_to_tone_and_duration.sv
// Channel   | Ports                        | Carries
// ----------+------------------------------+------------------------------------------
// note in   | s_tvalid s_tready s_tdata    | one note request
// result    | m_tvalid m_tready m_tdata    | valid flag, frequency, duration
// config    | cfg_we cfg_wdata             | beat length in ms, 0 selects 750
//
// A note with a positive length code or an invalid note goes from accept straight to
// the store step; a valid note with a negative length code first passes through the
// 16-step restoring divider that forms one quotient bit per cycle.
// One note is in work at a time; s_tready returns once its result enters the output register.
// Reset clears the controller, the output valid and the beat register; nothing to sweep.
// A stalled result holds the finished note in the store step until m_tready frees the register.
module note_to_tone_and_duration (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // accidental_char[7:0], degree_char[15:8], octave[20:16],
                                   // length_code[26:21], dotted[27], zero[31:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // valid_res[0], frequency_hz[13:1], duration_ms[33:14],
                                   // zero[39:34]
);
    import ntd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ntd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ntd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/ntd_ctrl.sv
module ntd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ntd_pkg::sts_t sts,
    output ntd_pkg::cmd_t cmd
);
    import ntd_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.needs_div ? ST_DIV : ST_STORE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.needs_div) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("divide request did not start the divider");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == LAST_STEP) |=> (state_reg == ST_STORE))
        else $error("divider did not finish after the last step");

    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> sts.out_free)
        else $error("store while output register still held");

endmodule

### rtl/ntd_dp.sv
module ntd_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic [31:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,
    input  ntd_pkg::cmd_t          cmd,
    output ntd_pkg::sts_t          sts
);
    import ntd_pkg::*;

    note_t note;
    logic [BEAT_W-1:0] base_reg;
    logic [BEAT_W-1:0] beat;
    logic deg_ok, is_rest, oct_ok, len_ok, pitch_ok, ok;
    logic signed [4:0] semi;
    logic [3:0] semi_idx;
    logic [3:0] oct_u;
    logic [FREQ_W-1:0] tone, freq;
    logic [5:0] len_mag;
    logic [DUR_W-1:0] dur_pos;

    logic valid_w_reg;
    logic [FREQ_W-1:0] freq_w_reg;
    logic [DUR_W-1:0] dur_w_reg;
    logic div_mode_reg;
    logic [BEAT_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W:0] trial;

    logic out_valid_reg, out_valid_next;
    result_t out_reg;

    assign note = note_t'(s_tdata);
    assign beat = (base_reg == '0) ? DEFAULT_BEAT : base_reg;

    always_comb
    begin
        deg_ok = (note.degree_char >= CH_REST) && (note.degree_char <= CH_TOP);
        is_rest = (note.degree_char == CH_REST);
        semi = signed'({1'b0, semitone_of(note.degree_char[2:0])});
        if (note.accidental_char == CH_SHARP)
        begin
            semi = semi + 5'sd1;
        end
        else if (note.accidental_char == CH_FLAT)
        begin
            semi = semi - 5'sd1;
        end
        oct_ok = !note.octave[4] && (note.octave <= 5'sd8);
        if (note.octave == 5'sd0 && semi < LOW_OCT_MIN_SEMI)
        begin
            oct_ok = 1'b0;
        end
        if (note.octave == 5'sd8 && semi > 5'sd0)
        begin
            oct_ok = 1'b0;
        end
        if (semi < 5'sd0)
        begin
            semi_idx = 4'd11;
        end
        else if (semi > 5'sd11)
        begin
            semi_idx = 4'd0;
        end
        else
        begin
            semi_idx = semi[3:0];
        end
        tone = tone_of(semi_idx);
        oct_u = note.octave[3:0];
        if (oct_u >= 4'd4)
        begin
            freq = tone << (oct_u - 4'd4);
        end
        else
        begin
            freq = tone >> (4'd4 - oct_u);
        end
        if (is_rest)
        begin
            freq = '0;
        end
        pitch_ok = deg_ok && (is_rest || oct_ok);
        len_ok = (note.length_code != 6'sd0) && (note.length_code >= -6'sd16)
            && (note.length_code <= 6'sd8);
        ok = pitch_ok && len_ok;
        len_mag = 6'(-note.length_code);
        dur_pos = {4'b0, beat} * {16'b0, note.length_code[3:0]};
        if (note.dotted)
        begin
            dur_pos = dur_pos + {5'b0, beat[BEAT_W-1:1]};
        end
    end

    always_comb
    begin
        sts.needs_div = ok && note.length_code[5];
        sts.out_free = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        trial = {rem_reg, quot_reg[BEAT_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
            quot_next = {quot_reg[BEAT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
            quot_next = {quot_reg[BEAT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            valid_w_reg <= ok;
            freq_w_reg <= ok ? freq : '0;
            dur_w_reg <= (ok && !note.length_code[5]) ? dur_pos : '0;
            div_mode_reg <= ok && note.length_code[5];
            quot_reg <= beat;
            rem_reg <= '0;
            div_reg <= len_mag[DIV_W-1:0];
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            out_reg.pad <= '0;
            out_reg.valid_res <= valid_w_reg;
            out_reg.frequency_hz <= freq_w_reg;
            out_reg.duration_ms <= div_mode_reg ? {4'b0, quot_reg} : dur_w_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (div_mode_reg && div_reg != '0 && rem_reg < div_reg))
        else $error("divider remainder out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.valid_res)
            |-> (out_reg.frequency_hz == '0 && out_reg.duration_ms == '0))
        else $error("invalid note carries nonzero fields");

endmodule
